/* hdl/pwc_pkg.sv */
`default_nettype none

package pwc_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  localparam int TIME_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [TIME_W-1:0] PERIOD_RESET = 16'd18750;
  localparam logic [TIME_W-1:0] EMPTY_VALUE = '1;

  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_ON_RISING = 2'd1;

  typedef logic [TIME_W-1:0] sample_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    KIND_CAPTURE = 2'd0,
    KIND_TIMEOUT = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  function automatic idx_t next_slot(input idx_t i);
    return (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

endpackage

`default_nettype wire

/* hdl/pwm_pulse_width_capture_core.sv */
// Pulse width capture core.
// Input channel (in_valid / in_stall) carries one event per transfer: a capture
// edge (kind, capture_time, pin_level, capture_pending), a compare timeout or a
// read of the sample queue. Every transfer produces exactly one result on the
// output channel (out_valid / out_stall): the popped sample or all ones,
// sample_valid, the current timeout deadline and awaiting_start.
// The result is registered at the edge that takes the event. Throughput is one
// event per cycle while the receiver does not stall; all state updates (edge
// timing, deadline add, queue push or pop) finish at that same edge.
// While the receiver stalls, the result register holds and in_stall is raised
// until the result is transferred; an event arriving in the cycle the result
// leaves is taken at once.
// The configuration channel (cfg_valid / cfg_ready) is always ready; index 0
// writes pulse_period, index 1 writes start_on_rising, others are ignored.
// Synchronous reset restores pulse_period to 18750, rising-edge start, an
// empty queue and a zero deadline; the queue contents need no clearing.
`default_nettype none

module pwm_pulse_width_capture_core
  import pwc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]      cfg_data,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             kind,
  input  wire logic [TIME_W-1:0]      capture_time,
  input  wire logic                   pin_level,
  input  wire logic                   capture_pending,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [TIME_W-1:0]           sample_value,
  output logic                        sample_valid,
  output logic [TIME_W-1:0]           timeout_deadline,
  output logic                        awaiting_start
);

  sample_t pulse_period;
  logic    start_on_rising;

  sample_t pulse_start_time, pulse_start_time_next;
  sample_t pulse_stop_time, pulse_stop_time_next;
  logic    waiting_for_start, waiting_for_start_next;
  sample_t deadline, deadline_next;
  idx_t    read_index, read_index_next;
  idx_t    write_index, write_index_next;

  sample_t sample_store [QUEUE_DEPTH];

  logic    accept;
  logic    active;
  logic    push;
  sample_t push_value;
  logic    pop;
  idx_t    write_slot;
  sample_t start_deadline;

  assign cfg_ready = 1'b1;
  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  assign active = (pin_level == start_on_rising);
  assign start_deadline = sample_t'(capture_time + pulse_period + sample_t'(1));
  assign write_slot = next_slot(write_index);

  always_comb begin
    pulse_start_time_next = pulse_start_time;
    pulse_stop_time_next = pulse_stop_time;
    waiting_for_start_next = waiting_for_start;
    deadline_next = deadline;
    push = 1'b0;
    push_value = '0;
    pop = 1'b0;
    case (kind_t'(kind))
      KIND_CAPTURE: begin
        if (waiting_for_start) begin
          push = 1'b1;
          push_value = sample_t'(pulse_stop_time - pulse_start_time);
          pulse_start_time_next = capture_time;
          deadline_next = start_deadline;
          if (active || capture_pending) begin
            waiting_for_start_next = 1'b0;
          end else begin
            waiting_for_start_next = 1'b1;
            pulse_stop_time_next = capture_time;
          end
        end else begin
          pulse_stop_time_next = capture_time;
          if (active && !capture_pending) begin
            push = 1'b1;
            push_value = sample_t'(capture_time - pulse_start_time);
            pulse_start_time_next = capture_time;
            deadline_next = start_deadline;
            waiting_for_start_next = 1'b0;
          end else begin
            waiting_for_start_next = 1'b1;
          end
        end
      end
      KIND_TIMEOUT: begin
        deadline_next = sample_t'(deadline + pulse_period);
        push = 1'b1;
        push_value = waiting_for_start ? '0 : pulse_period;
      end
      KIND_READ: begin
        pop = (read_index != write_index);
      end
      default: begin
      end
    endcase
    write_index_next = (push && (write_slot != read_index)) ? write_slot : write_index;
    read_index_next = pop ? next_slot(read_index) : read_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_period <= PERIOD_RESET;
      start_on_rising <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PULSE_PERIOD) begin
        pulse_period <= cfg_data;
      end else if (cfg_index == CFG_START_ON_RISING) begin
        start_on_rising <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_start_time <= '0;
      pulse_stop_time <= '0;
      waiting_for_start <= 1'b1;
      deadline <= '0;
      read_index <= '0;
      write_index <= '0;
    end else if (accept) begin
      pulse_start_time <= pulse_start_time_next;
      pulse_stop_time <= pulse_stop_time_next;
      waiting_for_start <= waiting_for_start_next;
      deadline <= deadline_next;
      read_index <= read_index_next;
      write_index <= write_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      sample_store[write_index] <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_value <= pop ? sample_store[read_index] : EMPTY_VALUE;
      sample_valid <= pop;
      timeout_deadline <= deadline_next;
      awaiting_start <= waiting_for_start_next;
    end
  end

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sample_valid) |-> (sample_value == EMPTY_VALUE))
    else $error("result without sample must read all ones");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (read_index <= idx_t'(QUEUE_DEPTH - 1)) && (write_index <= idx_t'(QUEUE_DEPTH - 1)))
    else $error("queue index out of range");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_READ) && (read_index == write_index))
      |=> (out_valid && !sample_valid))
    else $error("read of empty queue returned a sample");

  a_timeout_step: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_TIMEOUT))
      |=> ((deadline == sample_t'($past(deadline) + $past(pulse_period)))
           && (timeout_deadline == deadline)))
    else $error("timeout did not advance deadline by one period");

endmodule

`default_nettype wire
